/* hw/rtl/paged_ring_byte_buffer_macros.svh */
// Assertion macros used by the checker file.
`ifndef PAGED_RING_BYTE_BUFFER_MACROS_SVH
`define PAGED_RING_BYTE_BUFFER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PRBB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PRBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/prbb_pkg.sv */
// Shared types, codes and defaults of the paged ring byte buffer.
package prbb_pkg;

  localparam int DEF_BUFFER_DEPTH = 256;
  localparam int DEF_QUEUE_DEPTH  = 4;
  localparam int ADDR_W_MAX       = 16;  // enough for the deepest store
  localparam int PAGE_W           = 7;
  localparam int FILL_W           = 9;

  localparam logic [PAGE_W-1:0] PAGE_MAX   = 7'd64;
  localparam logic [PAGE_W-1:0] PAGE_RESET = 7'd32;

  // Input modes
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_APPEND_OK = 2'd0;
  localparam logic [1:0] ST_PAGE_BYTE = 2'd1;
  localparam logic [1:0] ST_NOTHING   = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        out_byte;
    logic              last;
    logic              ready_flag;
    logic [FILL_W-1:0] fill_count;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_APPEND,
    CMD_FLUSH
  } cmd_kind_t;

  // Command handed from the front to the back. Addresses are sized for the
  // deepest store; modules keep only the low bits they need.
  typedef struct packed {
    cmd_kind_t             kind;
    logic [7:0]            data;
    logic [ADDR_W_MAX-1:0] addr;      // append address or zero-fill start
    logic [ADDR_W_MAX-1:0] head;      // first window byte of a flush
    logic [PAGE_W-1:0]     page;      // bytes to emit
    logic [PAGE_W-1:0]     zero_cnt;  // cells to clear after a flush
    logic                  ready;
    logic [FILL_W-1:0]     fill;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_ZERO
  } back_state_t;

endpackage

/* hw/rtl/prbb_front.sv */
// Front: takes input beats, keeps the pointer state, turns each beat into a command.
module prbb_front #(
  parameter int BUFFER_DEPTH = prbb_pkg::DEF_BUFFER_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  prbb_pkg::in_item_t           in_item,
  input  logic                         cfg_we,
  input  logic [prbb_pkg::PAGE_W-1:0]  cfg_data,
  output prbb_pkg::cmd_t               cmd
);

  localparam int IW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] wi_r, wi_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic          ready_r, ready_nxt;
  logic [prbb_pkg::PAGE_W-1:0] page_size_r;

  logic [prbb_pkg::PAGE_W-1:0] pg;
  logic [CW-1:0]               pg_c;
  logic [IW-1:0]               wi_inc;
  logic [IW:0]                 head_sum;
  logic [IW-1:0]               head_adv;
  logic [IW:0]                 span_raw;
  logic [CW-1:0]               span;
  logic [CW-1:0]               held_inc;
  logic                        full_page;
  logic [IW-1:0]               head_f;
  logic [CW-1:0]               held_f;
  logic [prbb_pkg::PAGE_W-1:0] zero_f;
  logic                        do_flush;

  // effective page size: zero means one, clamp to the most a flush emits
  always_comb begin
    if (page_size_r == '0) begin
      pg = prbb_pkg::PAGE_W'(1);
    end else if (page_size_r > prbb_pkg::PAGE_MAX) begin
      pg = prbb_pkg::PAGE_MAX;
    end else begin
      pg = page_size_r;
    end
  end

  assign pg_c     = CW'(pg);
  assign wi_inc   = (wi_r == IW'(BUFFER_DEPTH - 1)) ? '0 : wi_r + 1'b1;
  assign held_inc = (held_r < CW'(BUFFER_DEPTH)) ? held_r + 1'b1 : held_r;

  // window slide arithmetic, all mod BUFFER_DEPTH
  assign head_sum  = {1'b0, head_r} + (IW+1)'(pg);
  assign head_adv  = (head_sum >= (IW+1)'(BUFFER_DEPTH)) ?
                     IW'(head_sum - (IW+1)'(BUFFER_DEPTH)) : IW'(head_sum);
  assign span_raw  = (wi_r >= head_adv) ? {1'b0, wi_r} - {1'b0, head_adv} :
                     {1'b0, wi_r} + (IW+1)'(BUFFER_DEPTH) - {1'b0, head_adv};
  assign span      = CW'(span_raw);
  assign full_page = (held_r >= pg_c);
  assign head_f    = full_page ? head_adv : wi_r;
  assign held_f    = full_page ? span : '0;
  assign zero_f    = (held_f < pg_c) ? prbb_pkg::PAGE_W'(pg_c - held_f) : '0;

  always_comb begin
    head_nxt  = head_r;
    wi_nxt    = wi_r;
    held_nxt  = held_r;
    ready_nxt = ready_r;
    do_flush  = 1'b0;
    cmd.kind  = prbb_pkg::CMD_NONE;
    case (in_item.mode)
      prbb_pkg::MODE_APPEND: begin
        cmd.kind  = prbb_pkg::CMD_APPEND;
        wi_nxt    = wi_inc;
        held_nxt  = held_inc;
        ready_nxt = ready_r | (held_inc >= pg_c);
      end
      prbb_pkg::MODE_READ: begin
        ready_nxt = 1'b0;
        do_flush  = ready_r && (held_r != '0);
      end
      prbb_pkg::MODE_FLUSH: begin
        do_flush = (held_r != '0);
      end
      default: begin
        cmd.kind = prbb_pkg::CMD_NONE;
      end
    endcase
    if (do_flush) begin
      cmd.kind = prbb_pkg::CMD_FLUSH;
      head_nxt = head_f;
      held_nxt = held_f;
    end
    cmd.data     = in_item.data_byte;
    cmd.addr     = prbb_pkg::ADDR_W_MAX'(wi_r);
    cmd.head     = prbb_pkg::ADDR_W_MAX'(head_r);
    cmd.page     = pg;
    cmd.zero_cnt = zero_f;
    cmd.ready    = ready_nxt;
    cmd.fill     = prbb_pkg::FILL_W'(held_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      wi_r        <= '0;
      held_r      <= '0;
      ready_r     <= 1'b0;
      page_size_r <= prbb_pkg::PAGE_RESET;
    end else begin
      if (accept) begin
        head_r  <= head_nxt;
        wi_r    <= wi_nxt;
        held_r  <= held_nxt;
        ready_r <= ready_nxt;
      end
      if (cfg_we) begin
        page_size_r <= cfg_data;
      end
    end
  end

endmodule

/* hw/rtl/prbb_queue.sv */
// Short command queue between front and back.
module prbb_queue #(
  parameter int QUEUE_DEPTH = prbb_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  prbb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output prbb_pkg::cmd_t head_cmd
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  prbb_pkg::cmd_t slot_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt;
  logic [PW-1:0]  rd_r, rd_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == NW'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = slot_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/prbb_back.sv */
// Back: owns the byte store, runs commands, drives the registered result beat.
module prbb_back #(
  parameter int BUFFER_DEPTH = prbb_pkg::DEF_BUFFER_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  prbb_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_stall,
  output prbb_pkg::out_item_t out_item
);

  localparam int IW = $clog2(BUFFER_DEPTH);

  logic [7:0] mem [BUFFER_DEPTH];

  prbb_pkg::back_state_t state_r, state_nxt;
  prbb_pkg::cmd_t        cmd_r;
  logic [IW-1:0]         addr_r, addr_nxt;
  logic [prbb_pkg::PAGE_W-1:0] idx_r, idx_nxt;
  logic [7:0]            rd_q;
  logic                  rd_pend_r, rd_pend_nxt;
  logic                  rd_last_r, rd_last_nxt;
  logic                  out_valid_r, out_valid_nxt;
  prbb_pkg::out_item_t   out_res_r, out_res_nxt;

  logic                  mem_we;
  logic [IW-1:0]         mem_wa;
  logic [7:0]            mem_wd;
  logic                  rd_en;
  logic                  ld_dir;
  prbb_pkg::out_item_t   dir_res;
  logic                  take_flush;

  logic          slot_free, rd_to_out, emit_free, can_issue;
  logic          read_last, zero_last;
  logic [IW-1:0] addr_inc;

  assign slot_free = !out_valid_r || !out_stall;
  assign rd_to_out = rd_pend_r && slot_free;
  assign emit_free = slot_free && !rd_pend_r;
  assign can_issue = !rd_pend_r || rd_to_out;
  assign read_last = (idx_r == cmd_r.page - 1'b1);
  assign zero_last = (idx_r == cmd_r.zero_cnt - 1'b1);
  assign addr_inc  = (addr_r == IW'(BUFFER_DEPTH - 1)) ? '0 : addr_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prbb_pkg::BK_CLEAR: begin
        if (addr_r == IW'(BUFFER_DEPTH - 1)) begin
          state_nxt = prbb_pkg::BK_IDLE;
        end
      end
      prbb_pkg::BK_IDLE: begin
        if (q_valid && q_cmd.kind == prbb_pkg::CMD_FLUSH && !rd_pend_r) begin
          state_nxt = prbb_pkg::BK_READ;
        end
      end
      prbb_pkg::BK_READ: begin
        if (can_issue && read_last) begin
          state_nxt = (cmd_r.zero_cnt != '0) ? prbb_pkg::BK_ZERO : prbb_pkg::BK_IDLE;
        end
      end
      prbb_pkg::BK_ZERO: begin
        if (zero_last) begin
          state_nxt = prbb_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = prbb_pkg::BK_IDLE;
      end
    endcase
  end

  // datapath controls
  always_comb begin
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = addr_r;
    mem_wd      = '0;
    rd_en       = 1'b0;
    ld_dir      = 1'b0;
    dir_res     = '0;
    take_flush  = 1'b0;
    addr_nxt    = addr_r;
    idx_nxt     = idx_r;
    rd_last_nxt = rd_last_r;
    case (state_r)
      prbb_pkg::BK_CLEAR: begin
        mem_we   = 1'b1;
        addr_nxt = addr_inc;
      end
      prbb_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            prbb_pkg::CMD_APPEND: begin
              if (emit_free) begin
                q_pop  = 1'b1;
                mem_we = 1'b1;
                mem_wa = IW'(q_cmd.addr);
                mem_wd = q_cmd.data;
                ld_dir = 1'b1;
                dir_res.status = prbb_pkg::ST_APPEND_OK;
              end
            end
            prbb_pkg::CMD_FLUSH: begin
              if (!rd_pend_r) begin
                q_pop      = 1'b1;
                take_flush = 1'b1;
                addr_nxt   = IW'(q_cmd.head);
                idx_nxt    = '0;
              end
            end
            default: begin
              if (emit_free) begin
                q_pop  = 1'b1;
                ld_dir = 1'b1;
                dir_res.status = prbb_pkg::ST_NOTHING;
              end
            end
          endcase
          dir_res.out_byte   = '0;
          dir_res.last       = 1'b1;
          dir_res.ready_flag = q_cmd.ready;
          dir_res.fill_count = q_cmd.fill;
        end
      end
      prbb_pkg::BK_READ: begin
        if (can_issue) begin
          rd_en       = 1'b1;
          rd_last_nxt = read_last;
          addr_nxt    = read_last ? IW'(cmd_r.addr) : addr_inc;
          idx_nxt     = read_last ? '0 : idx_r + 1'b1;
        end
      end
      prbb_pkg::BK_ZERO: begin
        mem_we   = 1'b1;
        addr_nxt = addr_inc;
        idx_nxt  = idx_r + 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // result register: a pending store byte goes first, then direct beats
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    rd_pend_nxt   = rd_pend_r;
    if (rd_to_out) begin
      out_valid_nxt          = 1'b1;
      out_res_nxt.status     = prbb_pkg::ST_PAGE_BYTE;
      out_res_nxt.out_byte   = rd_q;
      out_res_nxt.last       = rd_last_r;
      out_res_nxt.ready_flag = cmd_r.ready;
      out_res_nxt.fill_count = cmd_r.fill;
      rd_pend_nxt            = 1'b0;
    end else if (ld_dir) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = dir_res;
    end else if (slot_free) begin
      out_valid_nxt = 1'b0;
    end
    if (rd_en) begin
      rd_pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    rd_last_r <= rd_last_nxt;
    if (take_flush) begin
      cmd_r <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prbb_pkg::BK_CLEAR;
      addr_r      <= '0;
      idx_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      idx_r       <= idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign clearing  = (state_r == prbb_pkg::BK_CLEAR);
  assign out_valid = out_valid_r;
  assign out_item  = out_res_r;

endmodule

/* hw/rtl/paged_ring_byte_buffer.sv */
// Paged ring byte buffer: top level tying front, command queue and back.
// An append or a no-flush beat passes through the command queue and the result register.
// Throughput: appends and no-flush beats run at 1 per cycle while out_stall is low and no flush
//   holds the back; a flush holds the back through its page walk and zero fill, set by the one store port.
// Reset (rst_n low, synchronous) clears pointers and flags; then a clearing pass zeroes
//   every cell of the store with in_stall high. Config writes are always taken.
module paged_ring_byte_buffer #(
  parameter int BUFFER_DEPTH = prbb_pkg::DEF_BUFFER_DEPTH,  // 64 .. 511, so fill_count fits
  parameter int QUEUE_DEPTH  = prbb_pkg::DEF_QUEUE_DEPTH    // 2 and up
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input beats
  input  logic                        in_valid,
  output logic                        in_stall,
  input  prbb_pkg::in_item_t          in_item,
  // result beats
  output logic                        out_valid,
  input  logic                        out_stall,
  output prbb_pkg::out_item_t         out_item,
  // page_size register
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [prbb_pkg::PAGE_W-1:0] cfg_data
);

  logic           accept;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  logic           clearing;
  prbb_pkg::cmd_t front_cmd;
  prbb_pkg::cmd_t q_cmd;

  // Hold the input side during the clearing pass and whenever the queue is full.
  // The queue lets appends keep coming while the back walks a page.
  assign in_stall  = clearing | q_full;
  assign accept    = in_valid & ~in_stall;
  // page_size is sampled into each command, so a write never disturbs queued work
  assign cfg_ready = 1'b1;

  // Front: pointer bookkeeping and classification, one beat per cycle while in_stall is low.
  prbb_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_item),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (front_cmd)
  );

  prbb_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_cmd  (q_cmd)
  );

  // Back: byte store, page walk, zero fill and the registered result beat.
  prbb_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* hw/rtl/prbb_checker.sv */
// Port-level checker for the paged ring byte buffer, bound to the top level.
`include "paged_ring_byte_buffer_macros.svh"

module prbb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input prbb_pkg::out_item_t out_item
);

  `PRBB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result beat changed")
  `PRBB_ASSERT_NOW(a_zero_byte, out_valid && out_item.status != prbb_pkg::ST_PAGE_BYTE, out_item.out_byte == 8'd0, "non-page beat carries a byte")
  `PRBB_ASSERT_NOW(a_single_last, out_valid && out_item.status != prbb_pkg::ST_PAGE_BYTE, out_item.last, "single-beat result without last")
  `PRBB_ASSERT_NOW(a_clear_stall, $rose(rst_n), in_stall, "input open during store clearing")

endmodule

bind paged_ring_byte_buffer prbb_checker u_prbb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
